// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must hold at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/fppid_pkg.sv
// ----------------------------------------------------------------------------
// fppid_pkg
// types, constants and saturation helpers of the fixed point pid controller
// ----------------------------------------------------------------------------
`default_nettype none

package fppid_pkg;

    localparam int DATA_W      = 16;
    localparam int ACC_W       = 32;
    localparam int PROD_PD_W   = 2 * DATA_W;
    localparam int PROD_I_W    = DATA_W + ACC_W;
    localparam int SUM_W       = PROD_I_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GAIN_SHIFT_DEF = 8;

    localparam logic signed [DATA_W-1:0] S16_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] S16_MIN = 16'sh8000;
    localparam logic signed [ACC_W-1:0]  S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [ACC_W-1:0]  S32_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_DRIVE_LOW  = 3'd3,
        REG_DRIVE_HIGH = 3'd4,
        REG_ACCUM_LOW  = 3'd5,
        REG_ACCUM_HIGH = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] drive_low;
        logic signed [DATA_W-1:0] drive_high;
        logic signed [ACC_W-1:0]  accum_low;
        logic signed [ACC_W-1:0]  accum_high;
    } t_cfg;

    // saturate a 17 bit difference to 16 bits
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > (DATA_W+1)'(S16_MAX)) begin
            r = S16_MAX;
        end else if (v < (DATA_W+1)'(S16_MIN)) begin
            r = S16_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/fppid_cfg.sv
// ----------------------------------------------------------------------------
// fppid_cfg
// configuration register file of the pid controller
// ----------------------------------------------------------------------------
`default_nettype none

module fppid_cfg import fppid_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GAIN_P:     n_cfg.gain_p     = i_cfg_data[DATA_W-1:0];
                REG_GAIN_I:     n_cfg.gain_i     = i_cfg_data[DATA_W-1:0];
                REG_GAIN_D:     n_cfg.gain_d     = i_cfg_data[DATA_W-1:0];
                REG_DRIVE_LOW:  n_cfg.drive_low  = i_cfg_data[DATA_W-1:0];
                REG_DRIVE_HIGH: n_cfg.drive_high = i_cfg_data[DATA_W-1:0];
                REG_ACCUM_LOW:  n_cfg.accum_low  = i_cfg_data[ACC_W-1:0];
                REG_ACCUM_HIGH: n_cfg.accum_high = i_cfg_data[ACC_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= '0;
            r_cfg.gain_i     <= '0;
            r_cfg.gain_d     <= '0;
            r_cfg.drive_low  <= S16_MIN;
            r_cfg.drive_high <= S16_MAX;
            r_cfg.accum_low  <= S32_MIN;
            r_cfg.accum_high <= S32_MAX;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// File: src/fixed_point_pid_controller.sv
// ----------------------------------------------------------------------------
// fixed_point_pid_controller
// Fixed point PID controller with anti-windup. One request is accepted per
// clock unless o_stall is high; its drive value passes the input register,
// error/integral stage, multiply stage, sum stage and output clamp register.
// The integral and previous error are updated in the error stage, which is
// the only feedback loop and allows back to back requests. Configuration
// writes are taken at any time, but must only be issued while no request
// is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fixed_point_pid_controller import fppid_pkg::*; #(
    parameter int GAIN_SHIFT = GAIN_SHIFT_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [DATA_W-1:0] i_sample,
    input  wire logic signed [DATA_W-1:0] i_setpoint,
    input  wire logic                     i_restart,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [DATA_W-1:0]      o_drive,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cfg cfg;

    fppid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // stage valids and flow control
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic s1_take;

    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign rdy0    = !r_v0 || rdy1;
    assign o_stall = !rdy0;
    assign o_valid = r_v4;
    assign s1_take = r_v0 && rdy1;

    // input register
    logic signed [DATA_W-1:0] r_in_sample, r_in_setpoint;
    logic                     r_in_restart;

    // controller state
    logic signed [ACC_W-1:0]  r_accum;
    logic signed [DATA_W-1:0] r_last_error;
    logic                     r_primed;

    // error / integral stage
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [DATA_W-1:0] last_base;
    logic                     primed_base;
    logic signed [DATA_W:0]   err_diff, der_diff;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [DATA_W-1:0] n_err, n_deriv;
    logic signed [ACC_W-1:0]  n_accum;
    logic                     acc_inv;

    assign acc_base    = r_in_restart ? '0 : r_accum;
    assign last_base   = r_in_restart ? '0 : r_last_error;
    assign primed_base = !r_in_restart && r_primed;
    assign err_diff    = (DATA_W+1)'(r_in_setpoint) - (DATA_W+1)'(r_in_sample);
    assign n_err       = sat16(err_diff);
    assign der_diff    = (DATA_W+1)'(n_err) - (DATA_W+1)'(last_base);
    assign n_deriv     = primed_base ? sat16(der_diff) : '0;
    assign acc_sum     = (ACC_W+1)'(acc_base) + (ACC_W+1)'(n_err);
    assign acc_inv     = cfg.accum_low > cfg.accum_high;

    always_comb begin
        if (acc_inv) begin
            if (acc_sum > (ACC_W+1)'(S32_MAX)) begin
                n_accum = S32_MAX;
            end else if (acc_sum < (ACC_W+1)'(S32_MIN)) begin
                n_accum = S32_MIN;
            end else begin
                n_accum = acc_sum[ACC_W-1:0];
            end
        end else begin
            if (acc_sum > (ACC_W+1)'(cfg.accum_high)) begin
                n_accum = cfg.accum_high;
            end else if (acc_sum < (ACC_W+1)'(cfg.accum_low)) begin
                n_accum = cfg.accum_low;
            end else begin
                n_accum = acc_sum[ACC_W-1:0];
            end
        end
    end

    logic signed [DATA_W-1:0]    r_s1_err, r_s1_deriv;
    logic signed [ACC_W-1:0]     r_s1_accum;
    logic signed [PROD_PD_W-1:0] r_prod_p, r_prod_d;
    logic signed [PROD_I_W-1:0]  r_prod_i;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [SUM_W-1:0]     n_sum, sum_shift;
    logic signed [SUM_W-1:0]     lo_ext, hi_ext;
    logic signed [DATA_W-1:0]    n_drive, r_drive;
    logic                        drv_inv;

    assign n_sum = SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);

    // output clamp
    assign sum_shift = r_sum >>> GAIN_SHIFT;
    assign drv_inv   = cfg.drive_low > cfg.drive_high;
    assign lo_ext    = drv_inv ? SUM_W'(S16_MIN) : SUM_W'(cfg.drive_low);
    assign hi_ext    = drv_inv ? SUM_W'(S16_MAX) : SUM_W'(cfg.drive_high);

    always_comb begin
        if (sum_shift > hi_ext) begin
            n_drive = hi_ext[DATA_W-1:0];
        end else if (sum_shift < lo_ext) begin
            n_drive = lo_ext[DATA_W-1:0];
        end else begin
            n_drive = sum_shift[DATA_W-1:0];
        end
    end

    assign o_drive = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0         <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_accum      <= '0;
            r_last_error <= '0;
            r_primed     <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (s1_take) begin
                r_accum      <= n_accum;
                r_last_error <= n_err;
                r_primed     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_valid) begin
            r_in_sample   <= i_sample;
            r_in_setpoint <= i_setpoint;
            r_in_restart  <= i_restart;
        end
        if (s1_take) begin
            r_s1_err   <= n_err;
            r_s1_deriv <= n_deriv;
            r_s1_accum <= n_accum;
        end
        if (r_v1 && rdy2) begin
            r_prod_p <= r_s1_err * cfg.gain_p;
            r_prod_d <= r_s1_deriv * cfg.gain_d;
            r_prod_i <= r_s1_accum * cfg.gain_i;
        end
        if (r_v2 && rdy3) begin
            r_sum <= n_sum;
        end
        if (r_v3 && rdy4) begin
            r_drive <= n_drive;
        end
    end

    `ASSERT_CLK(a_stall_full, i_clk, i_rst_n, o_stall |-> (r_v0 && r_v1 && r_v2 && r_v3 && r_v4), "input stalled while pipeline has a free stage")
    `ASSERT_CLK(a_primed_after, i_clk, i_rst_n, s1_take |=> r_primed, "state not primed after a request")
    `ASSERT_CLK(a_accum_bounds, i_clk, i_rst_n, (s1_take && !acc_inv) |=> ((r_accum >= $past(cfg.accum_low)) && (r_accum <= $past(cfg.accum_high))), "integral outside configured limits")
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")

endmodule

`default_nettype wire

// File: bench/tb_fixed_point_pid_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_pid_controller
// Self-checking bench for the fixed point pid controller. A behavioral copy of
// the controller predicts each drive value as a request is accepted; the
// results are checked in order as they leave the block. Directed cases cover
// error and derivative saturation, output and integral limits (inverted ones
// too) and the unused register index. Random phases follow, each with its own
// register settings and idling on each channel switched on or off by phase.
// ----------------------------------------------------------------------------

module tb_fixed_point_pid_controller;
    import fppid_pkg::*;

    localparam int PIPE_DEPTH = 5;
    localparam int SHIFT = GAIN_SHIFT_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [DATA_W-1:0]   i_sample = '0;
    logic signed [DATA_W-1:0]   i_setpoint = '0;
    logic                       i_restart = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [DATA_W-1:0]   o_drive;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    t_cfg                       ctl_cfg;
    logic signed [ACC_W-1:0]    ctl_integral;
    logic signed [DATA_W-1:0]   ctl_last_err;
    logic                       ctl_primed;
    logic signed [DATA_W-1:0]   held_target = '0;

    logic signed [DATA_W-1:0]   drive_q [$];
    int unsigned                mismatches = 0;
    bit                         tx_idle = 1'b0;
    bit                         rx_idle = 1'b0;
    int unsigned                hold_req = 0;
    int unsigned                rx_wait = 0;

    fixed_point_pid_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_setpoint  (i_setpoint),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_drive     (o_drive),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void reset_controller();
        ctl_cfg.gain_p     = '0;
        ctl_cfg.gain_i     = '0;
        ctl_cfg.gain_d     = '0;
        ctl_cfg.drive_low  = S16_MIN;
        ctl_cfg.drive_high = S16_MAX;
        ctl_cfg.accum_low  = S32_MIN;
        ctl_cfg.accum_high = S32_MAX;
        ctl_integral       = '0;
        ctl_last_err       = '0;
        ctl_primed         = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GAIN_P:     ctl_cfg.gain_p     = data[DATA_W-1:0];
            REG_GAIN_I:     ctl_cfg.gain_i     = data[DATA_W-1:0];
            REG_GAIN_D:     ctl_cfg.gain_d     = data[DATA_W-1:0];
            REG_DRIVE_LOW:  ctl_cfg.drive_low  = data[DATA_W-1:0];
            REG_DRIVE_HIGH: ctl_cfg.drive_high = data[DATA_W-1:0];
            REG_ACCUM_LOW:  ctl_cfg.accum_low  = data[ACC_W-1:0];
            REG_ACCUM_HIGH: ctl_cfg.accum_high = data[ACC_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pid_drive(logic signed [DATA_W-1:0] smp,
                                                           logic signed [DATA_W-1:0] tgt,
                                                           logic rst);
        longint err, der, y, lo, hi;
        if (rst) begin
            ctl_integral = '0;
            ctl_last_err = '0;
            ctl_primed   = 1'b0;
        end
        err = clip(longint'(tgt) - longint'(smp), S16_MIN, S16_MAX);
        if (!ctl_primed) begin
            der = 0;
            ctl_primed = 1'b1;
        end else begin
            der = clip(err - longint'(ctl_last_err), S16_MIN, S16_MAX);
        end
        if ($signed(ctl_cfg.accum_low) > $signed(ctl_cfg.accum_high)) begin
            lo = S32_MIN;
            hi = S32_MAX;
        end else begin
            lo = $signed(ctl_cfg.accum_low);
            hi = $signed(ctl_cfg.accum_high);
        end
        ctl_integral = ACC_W'(clip(longint'(ctl_integral) + err, lo, hi));
        y = longint'($signed(ctl_cfg.gain_p)) * err
          + longint'($signed(ctl_cfg.gain_i)) * longint'(ctl_integral)
          + longint'($signed(ctl_cfg.gain_d)) * der;
        y = y >>> SHIFT;
        if ($signed(ctl_cfg.drive_low) > $signed(ctl_cfg.drive_high)) begin
            y = clip(y, S16_MIN, S16_MAX);
        end else begin
            y = clip(y, $signed(ctl_cfg.drive_low), $signed(ctl_cfg.drive_high));
        end
        ctl_last_err = DATA_W'(err);
        return DATA_W'(y);
    endfunction

    function automatic logic [DATA_W-1:0] rand_small_gain();
        int v;
        v = $urandom_range(0, 1200);
        return DATA_W'(v - 600);
    endfunction

    // offer one request, predict its drive once accepted
    task automatic send_sample(input logic signed [DATA_W-1:0] smp,
                               input logic signed [DATA_W-1:0] tgt,
                               input logic rst);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_sample   <= smp;
        i_setpoint <= tgt;
        i_restart  <= rst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        drive_q.push_back(pid_drive(smp, tgt, rst));
    endtask

    task automatic send_random_item();
        logic signed [DATA_W-1:0] smp;
        logic signed [DATA_W-1:0] tgt;
        int unsigned pick;
        logic rst;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) held_target = DATA_W'($urandom());
        tgt = held_target;
        if (pick < 60) begin
            smp = tgt + DATA_W'($urandom_range(0, 512)) - DATA_W'(256);
        end else if (pick < 90) begin
            smp = DATA_W'($urandom());
            tgt = DATA_W'($urandom());
        end else begin
            smp = $urandom_range(0, 1) ? S16_MAX : S16_MIN;
            tgt = $urandom_range(0, 1) ? S16_MAX : S16_MIN;
        end
        rst = ($urandom_range(0, 15) == 0);
        send_sample(smp, tgt, rst);
    endtask

    // wait until every predicted drive has come out and the pipe is empty
    task automatic settle();
        i_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper bits of a 16 bit register write are don't care
    task automatic write_short(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        write_reg(idx, {16'($urandom()), v});
    endtask

    task automatic set_gains(input logic [DATA_W-1:0] gp, input logic [DATA_W-1:0] gi,
                             input logic [DATA_W-1:0] gd);
        write_short(REG_GAIN_P, gp);
        write_short(REG_GAIN_I, gi);
        write_short(REG_GAIN_D, gd);
    endtask

    task automatic set_limits(input logic [DATA_W-1:0] dlo, input logic [DATA_W-1:0] dhi,
                              input logic [ACC_W-1:0] alo, input logic [ACC_W-1:0] ahi);
        write_short(REG_DRIVE_LOW, dlo);
        write_short(REG_DRIVE_HIGH, dhi);
        write_reg(REG_ACCUM_LOW, alo);
        write_reg(REG_ACCUM_HIGH, ahi);
    endtask

    task automatic test_reset_state();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_sample(S16_MIN, S16_MAX, 1'b0);
        send_sample(S16_MAX, S16_MIN, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_error_saturation();
        set_gains(16'd256, 16'd0, 16'd256);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(S16_MIN, S16_MAX, 1'b0);
        send_sample(S16_MAX, S16_MIN, 1'b0);
        send_sample(16'sd100, 16'sd200, 1'b1);
        send_sample(16'sd100, 16'sd50, 1'b0);
    endtask

    task automatic test_output_limits();
        set_gains(S16_MAX, 16'd0, 16'd0);
        write_short(REG_DRIVE_LOW, -16'sd1000);
        write_short(REG_DRIVE_HIGH, 16'sd1000);
        send_sample(16'sd0, 16'sd500, 1'b1);
        send_sample(16'sd500, 16'sd0, 1'b0);
        // inverted output limits
        write_short(REG_DRIVE_LOW, 16'sd100);
        write_short(REG_DRIVE_HIGH, -16'sd100);
        send_sample(16'sd0, 16'sd5, 1'b0);
        send_sample(16'sd0, S16_MAX, 1'b0);
        send_sample(S16_MAX, S16_MIN, 1'b0);
        // shift rounds toward minus infinity
        write_short(REG_GAIN_P, 16'd1);
        send_sample(16'sd0, -16'sd1, 1'b0);
        write_short(REG_DRIVE_LOW, S16_MIN);
        write_short(REG_DRIVE_HIGH, S16_MAX);
    endtask

    task automatic test_integral_limits();
        set_gains(16'd0, 16'd256, 16'd0);
        write_reg(REG_ACCUM_LOW, -32'sd1000);
        write_reg(REG_ACCUM_HIGH, 32'sd1000);
        send_sample(16'sd0, 16'sd800, 1'b1);
        send_sample(16'sd0, 16'sd800, 1'b0);
        send_sample(16'sd800, 16'sd0, 1'b0);
        // park the integral near the top, then invert the limits
        write_short(REG_GAIN_I, 16'd1);
        write_reg(REG_ACCUM_LOW, 32'sd2147450000);
        write_reg(REG_ACCUM_HIGH, 32'sd2147450000);
        send_sample(16'sd0, 16'sd0, 1'b0);
        write_reg(REG_ACCUM_LOW, 32'sd1);
        write_reg(REG_ACCUM_HIGH, 32'sd0);
        send_sample(S16_MIN, S16_MAX, 1'b0);
        send_sample(S16_MIN, S16_MAX, 1'b0);
        send_sample(S16_MAX, S16_MIN, 1'b0);
        // same at the bottom
        write_reg(REG_ACCUM_LOW, -32'sd2147450000);
        write_reg(REG_ACCUM_HIGH, -32'sd2147450000);
        send_sample(16'sd0, 16'sd0, 1'b0);
        write_reg(REG_ACCUM_LOW, 32'sd1);
        write_reg(REG_ACCUM_HIGH, 32'sd0);
        send_sample(S16_MAX, S16_MIN, 1'b0);
        send_sample(S16_MAX, S16_MIN, 1'b0);
        send_sample(S16_MIN, S16_MAX, 1'b0);
        write_reg(REG_ACCUM_LOW, S32_MIN);
        write_reg(REG_ACCUM_HIGH, S32_MAX);
    endtask

    task automatic test_ignored_register();
        set_gains(16'd256, 16'd0, 16'd0);
        write_reg(REG_UNUSED, 32'hffff_ffff);
        send_sample(16'sd0, 16'sd10, 1'b1);
    endtask

    task automatic test_backpressure();
        set_gains(rand_small_gain(), rand_small_gain(), rand_small_gain());
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_req = 80;
        repeat (30) send_random_item();
        settle();
    endtask

    task automatic test_sender_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (20) send_random_item();
        settle();
        repeat (20) send_random_item();
    endtask

    task automatic test_random_phases();
        int unsigned phase;
        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin
                    set_gains(S16_MAX, S16_MAX, S16_MAX);
                    set_limits(S16_MIN, S16_MAX, S32_MIN, S32_MAX);
                end
                1: begin
                    set_gains(S16_MIN, S16_MIN, S16_MIN);
                    set_limits(S16_MIN, S16_MAX, S32_MIN, S32_MAX);
                end
                2: begin
                    set_gains(DATA_W'($urandom()), DATA_W'($urandom()), DATA_W'($urandom()));
                    set_limits(S16_MAX, S16_MIN, S32_MAX, S32_MIN);
                end
                default: begin
                    set_gains(rand_small_gain(), rand_small_gain(), rand_small_gain());
                    if ($urandom_range(0, 1)) begin
                        set_limits(DATA_W'($urandom()), DATA_W'($urandom()),
                                   $urandom(), $urandom());
                    end else begin
                        set_limits(DATA_W'($urandom()), DATA_W'($urandom()),
                                   -ACC_W'($urandom_range(0, 200000)),
                                   ACC_W'($urandom_range(0, 200000)));
                    end
                    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());
                end
            endcase
            tx_idle = (phase % 3) != 0;
            rx_idle = (phase % 2) != 0;
            repeat (45) send_random_item();
        end
    endtask

    // receiver: random stall per result, optional long hold, in-order check
    always @(posedge i_clk) begin : rx_check
        logic signed [DATA_W-1:0] want;
        if (!i_rst_n) begin
            rx_wait = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: drive expected none actual %0d", $time, o_drive);
                    mismatches++;
                end else begin
                    want = drive_q.pop_front();
                    if (o_drive !== want) begin
                        $display("%0t: drive expected %0d actual %0d", $time, want, o_drive);
                        mismatches++;
                    end
                end
                rx_wait = rx_idle ? $urandom_range(0, 14) : 0;
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            if (hold_req != 0) begin
                rx_wait  = hold_req;
                hold_req = 0;
            end
            i_stall <= (rx_wait != 0);
        end
    end

    initial begin
        #2_000_000;
        $display("tb_fixed_point_pid_controller NOT OK");
        $finish;
    end

    initial begin
        reset_controller();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_error_saturation();
        test_output_limits();
        test_integral_limits();
        test_ignored_register();
        test_backpressure();
        test_sender_pause();
        test_random_phases();
        settle();
        if (mismatches == 0 && drive_q.size() == 0) begin
            $display("tb_fixed_point_pid_controller OK");
        end else begin
            $display("tb_fixed_point_pid_controller NOT OK");
        end
        $finish;
    end

endmodule
